FILE: rtl/assert_macros.svh
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset
`define PRC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication on every rising clock edge, reset included
`define PRC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/prc_pkg.sv
package prc_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned DIFF_W  = 33;
    localparam int unsigned PROD_W  = 66;
    localparam int unsigned MODE_W  = 4;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CFG_IDX_W = 3;

    // Region modes
    localparam logic [MODE_W-1:0] MODE_IN_BOX   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_OUT_BOX  = 4'd1;
    localparam logic [MODE_W-1:0] MODE_IN_POLY  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_OUT_POLY = 4'd3;
    localparam logic [MODE_W-1:0] MODE_LEFT     = 4'd4;
    localparam logic [MODE_W-1:0] MODE_RIGHT    = 4'd5;
    localparam logic [MODE_W-1:0] MODE_ABOVE    = 4'd6;
    localparam logic [MODE_W-1:0] MODE_BELOW    = 4'd7;
    localparam logic [MODE_W-1:0] MODE_INACTIVE = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BX    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BY    = 3'd5;

    // Request types
    localparam logic REQ_LOAD     = 1'b0;
    localparam logic REQ_CLASSIFY = 1'b1;

endpackage

FILE: rtl/prc_ram.sv
module prc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/point_region_classifier_unit.sv
// Point region classifier.
// Input channel i_valid/o_stall carries one item: a vertex load (req_type 0),
// which writes slot vertex_index of the vertex store and gives no result, or
// a point classification (req_type 1), which gives one in_region result on
// the o_valid/i_stall output channel.
// The line and polygon tests share one compare unit: a cross-multiplied
// comparison of two 33 x 33 bit products, each taken as four partial products
// of 17-bit halves, then one compare step. A polygon test first reads vertex
// 0, then per edge takes one set-up step, four multiply steps and one compare,
// plus the ST_FETCH0 and ST_FETCH1 states to fetch the next vertex; an edge
// that cannot cross skips the multiply steps. Loads may follow back to back
// while the block is idle.
// The block takes one item at a time: o_stall is high while an item is at
// work. The result sits in an output register until it is transferred; a
// stalled result holds the block, and the next item is taken once it goes.
// Reset (i_rst_n low, synchronous) sets region_mode to inactive, vertex_count
// to 3 and the corners to 0. The vertex store is not cleared: a slot must be
// loaded before a polygon test reads it. Configuration writes are to be made
// only while the block is idle; the block itself does not enforce this.
module point_region_classifier_unit
    import prc_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_req_type,
    input  logic [INDEX_W-1:0]         i_vertex_index,
    input  logic signed [COORD_W-1:0]  i_point_x,
    input  logic signed [COORD_W-1:0]  i_point_y,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_in_region,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data
);

    localparam int unsigned ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int unsigned HALF_W = 17;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_FETCH0,
        ST_FETCH1,
        ST_EDGE,
        ST_MUL,
        ST_CMP,
        ST_DONE
    } t_state;

    // Configuration registers
    logic [MODE_W-1:0]         r_mode;
    logic [COUNT_W-1:0]        r_count;
    logic signed [COORD_W-1:0] r_ax, r_ay, r_bx, r_by;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_INACTIVE;
            r_count <= COUNT_W'(3);
            r_ax    <= '0;
            r_ay    <= '0;
            r_bx    <= '0;
            r_by    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODE:  r_mode  <= i_cfg_data[MODE_W-1:0];
                REG_COUNT: r_count <= i_cfg_data[COUNT_W-1:0];
                REG_AX:    r_ax    <= i_cfg_data;
                REG_AY:    r_ay    <= i_cfg_data;
                REG_BX:    r_bx    <= i_cfg_data;
                REG_BY:    r_by    <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // Vertex store
    logic              w_load;
    logic [ADDR_W-1:0] r_raddr;
    logic [COORD_W-1:0] w_vx, w_vy;
    logic              w_load_ok;

    assign w_load_ok = ({{(32-INDEX_W){1'b0}}, i_vertex_index} < 32'(MAX_VERTICES));

    prc_ram #(.WIDTH(COORD_W), .DEPTH(MAX_VERTICES)) u_ram_x (
        .i_clk   (i_clk),
        .i_we    (w_load && w_load_ok),
        .i_waddr (ADDR_W'(i_vertex_index)),
        .i_wdata (i_point_x),
        .i_raddr (r_raddr),
        .o_rdata (w_vx)
    );

    prc_ram #(.WIDTH(COORD_W), .DEPTH(MAX_VERTICES)) u_ram_y (
        .i_clk   (i_clk),
        .i_we    (w_load && w_load_ok),
        .i_waddr (ADDR_W'(i_vertex_index)),
        .i_wdata (i_point_y),
        .i_raddr (r_raddr),
        .o_rdata (w_vy)
    );

    // Sequencer state
    t_state                    r_state;
    logic signed [COORD_W-1:0] r_px, r_py;
    logic [CNT_W-1:0]          r_n;
    logic [CNT_W-1:0]          r_edge;
    logic signed [COORD_W-1:0] r_x0, r_y0;      // first vertex, closes polygon
    logic signed [COORD_W-1:0] r_x1, r_y1;      // current edge start
    logic                      r_parity;
    logic                      r_poly;
    logic                      r_invert;
    logic                      r_result;
    logic                      r_out_valid;
    // shared compare unit: is a*b <= c*d
    logic signed [DIFF_W-1:0]  r_a, r_b, r_c, r_d;
    logic signed [PROD_W+1:0]  r_acc;           // a*b - c*d
    logic [1:0]                r_step;

    assign w_load   = i_valid && !o_stall && (i_req_type == REQ_LOAD);
    assign o_stall  = (r_state != ST_IDLE) || r_out_valid;
    assign o_valid  = r_out_valid;
    assign o_in_region = r_result;

    // Edge set-up from the current vertex pair (x1,y1) -> (x2,y2)
    logic signed [COORD_W-1:0] w_x2, w_y2;
    logic signed [COORD_W-1:0] w_xa, w_ya, w_xb, w_yb;
    logic                      w_last;
    logic                      w_edge_live;

    assign w_last = (r_edge + CNT_W'(1) == r_n);
    assign w_x2 = w_last ? r_x0 : w_vx;
    assign w_y2 = w_last ? r_y0 : w_vy;
    always_comb begin
        if (r_y1 > w_y2) begin
            w_xa = w_x2; w_ya = w_y2; w_xb = r_x1; w_yb = r_y1;
        end else begin
            w_xa = r_x1; w_ya = r_y1; w_xb = w_x2; w_yb = w_y2;
        end
    end
    assign w_edge_live = (r_y1 != w_y2) && (r_py > w_ya) && (r_py <= w_yb);

    // Line set-up: sort the corners on y (left/right) or x (above/below)
    logic                      w_vert_sel;
    logic                      w_swap;
    logic signed [COORD_W-1:0] w_lxa, w_lya, w_lxb, w_lyb;
    logic                      w_degenerate;
    logic                      w_form_b;   // left/above use form (x-xa)(yb-ya)<=(y-ya)(xb-xa)

    assign w_vert_sel   = (r_mode == MODE_ABOVE) || (r_mode == MODE_BELOW);
    assign w_swap       = w_vert_sel ? (r_ax > r_bx) : (r_ay > r_by);
    assign w_degenerate = w_vert_sel ? (r_ax == r_bx) : (r_ay == r_by);
    assign w_form_b     = (r_mode == MODE_LEFT) || (r_mode == MODE_ABOVE);
    always_comb begin
        if (w_swap) begin
            w_lxa = r_bx; w_lya = r_by; w_lxb = r_ax; w_lyb = r_ay;
        end else begin
            w_lxa = r_ax; w_lya = r_ay; w_lxb = r_bx; w_lyb = r_by;
        end
    end

    // Partial products: step 0 a*b low halves etc. over 17-bit halves
    logic [DIFF_W-1:0]  w_ua, w_ub, w_uc, w_ud;
    logic               w_neg_ab, w_neg_cd;
    logic [HALF_W-1:0]  w_m0, w_m1, w_m2, w_m3;
    logic [2*HALF_W-1:0] w_pp_ab, w_pp_cd;
    logic [PROD_W+1:0]  w_sh_ab, w_sh_cd;
    logic [5:0]         w_shift;

    assign w_ua = r_a[DIFF_W-1] ? DIFF_W'(-r_a) : DIFF_W'(r_a);
    assign w_ub = r_b[DIFF_W-1] ? DIFF_W'(-r_b) : DIFF_W'(r_b);
    assign w_uc = r_c[DIFF_W-1] ? DIFF_W'(-r_c) : DIFF_W'(r_c);
    assign w_ud = r_d[DIFF_W-1] ? DIFF_W'(-r_d) : DIFF_W'(r_d);
    assign w_neg_ab = r_a[DIFF_W-1] ^ r_b[DIFF_W-1];
    assign w_neg_cd = r_c[DIFF_W-1] ^ r_d[DIFF_W-1];

    always_comb begin
        w_m0 = r_step[0] ? {1'b0, w_ua[DIFF_W-1 -: 16]} : w_ua[HALF_W-1:0];
        w_m1 = r_step[1] ? {1'b0, w_ub[DIFF_W-1 -: 16]} : w_ub[HALF_W-1:0];
        w_m2 = r_step[0] ? {1'b0, w_uc[DIFF_W-1 -: 16]} : w_uc[HALF_W-1:0];
        w_m3 = r_step[1] ? {1'b0, w_ud[DIFF_W-1 -: 16]} : w_ud[HALF_W-1:0];
        w_shift = 6'(HALF_W) * 6'({1'b0, r_step[0]} + {1'b0, r_step[1]});
    end
    assign w_pp_ab = w_m0 * w_m1;
    assign w_pp_cd = w_m2 * w_m3;
    assign w_sh_ab = (PROD_W+2)'(w_pp_ab) << w_shift;
    assign w_sh_cd = (PROD_W+2)'(w_pp_cd) << w_shift;

    logic signed [PROD_W+1:0] w_term;
    assign w_term = (w_neg_ab ? -$signed(w_sh_ab) : $signed(w_sh_ab))
                  - (w_neg_cd ? -$signed(w_sh_cd) : $signed(w_sh_cd));

    // Box test
    logic w_in_box;
    assign w_in_box = (r_px >= r_ax) && (r_px <= r_bx) && (r_py >= r_ay) && (r_py <= r_by);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_result    <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (r_out_valid && !i_stall) begin
                        r_out_valid <= 1'b0;
                    end
                    if (i_valid && !o_stall && i_req_type == REQ_CLASSIFY) begin
                        r_px    <= i_point_x;
                        r_py    <= i_point_y;
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    r_invert <= (r_mode == MODE_OUT_BOX) || (r_mode == MODE_OUT_POLY);
                    r_parity <= 1'b0;
                    r_edge   <= '0;
                    r_raddr  <= '0;
                    r_n      <= ({1'b0, r_count} > 32'(MAX_VERTICES)) ?
                                CNT_W'(MAX_VERTICES) : CNT_W'(r_count);
                    priority if (r_mode == MODE_IN_BOX || r_mode == MODE_OUT_BOX) begin
                        r_result <= w_in_box ^ (r_mode == MODE_OUT_BOX);
                        r_state  <= ST_DONE;
                    end else if (r_mode == MODE_IN_POLY || r_mode == MODE_OUT_POLY) begin
                        r_poly  <= 1'b1;
                        r_state <= (r_count == '0) ? ST_DONE : ST_FETCH0;
                        r_result <= (r_mode == MODE_OUT_POLY);
                    end else if (r_mode >= MODE_LEFT && r_mode <= MODE_BELOW) begin
                        r_poly <= 1'b0;
                        if (w_degenerate) begin
                            r_result <= 1'b0;
                            r_state  <= ST_DONE;
                        end else begin
                            if (w_form_b) begin
                                r_a <= DIFF_W'(r_px) - DIFF_W'(w_lxa);
                                r_b <= DIFF_W'(w_lyb) - DIFF_W'(w_lya);
                                r_c <= DIFF_W'(r_py) - DIFF_W'(w_lya);
                                r_d <= DIFF_W'(w_lxb) - DIFF_W'(w_lxa);
                            end else begin
                                r_a <= DIFF_W'(r_py) - DIFF_W'(w_lya);
                                r_b <= DIFF_W'(w_lxb) - DIFF_W'(w_lxa);
                                r_c <= DIFF_W'(r_px) - DIFF_W'(w_lxa);
                                r_d <= DIFF_W'(w_lyb) - DIFF_W'(w_lya);
                            end
                            r_acc  <= '0;
                            r_step <= '0;
                            r_state <= ST_MUL;
                        end
                    end else begin
                        r_result <= 1'b0;
                        r_state  <= ST_DONE;
                    end
                end
                ST_FETCH0: begin
                    // read data of the addressed vertex arrives next cycle
                    r_state <= ST_FETCH1;
                end
                ST_FETCH1: begin
                    // latch vertex 0 on the first pass, else go on to the edge
                    if (r_poly) begin
                        r_x0    <= w_vx;
                        r_y0    <= w_vy;
                        r_x1    <= w_vx;
                        r_y1    <= w_vy;
                        r_raddr <= (r_n > CNT_W'(1)) ? ADDR_W'(1) : '0;
                        r_poly  <= 1'b0;
                        r_state <= ST_FETCH0;
                    end else begin
                        r_state <= ST_EDGE;
                    end
                end
                ST_EDGE: begin
                    // vertex read data for edge end is valid here
                    if (w_edge_live) begin
                        r_a <= DIFF_W'(r_py) - DIFF_W'(w_ya);
                        r_b <= DIFF_W'(w_xb) - DIFF_W'(w_xa);
                        r_c <= DIFF_W'(r_px) - DIFF_W'(w_xa);
                        r_d <= DIFF_W'(w_yb) - DIFF_W'(w_ya);
                        r_acc  <= '0;
                        r_step <= '0;
                        r_state <= ST_MUL;
                    end else begin
                        r_state <= ST_CMP;
                        r_acc   <= '1;   // negative flag ignored: no crossing
                        r_step  <= 2'd1;
                    end
                    r_x1 <= w_x2;
                    r_y1 <= w_y2;
                end
                ST_MUL: begin
                    // step wraps back to zero after the last partial product
                    r_acc  <= r_acc + w_term;
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        r_state <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    if (r_edge >= r_n || r_n == '0 || !r_invert && !(r_mode == MODE_IN_POLY)) begin
                        r_result <= (r_acc <= 0);
                        r_state  <= ST_DONE;
                    end else begin
                        if (r_step == 2'd0) begin
                            r_parity <= r_parity ^ (r_acc <= 0);
                        end
                        if (w_last) begin
                            r_result <= r_parity ^ ((r_step == 2'd0) && (r_acc <= 0)) ^ r_invert;
                            r_state  <= ST_DONE;
                        end else begin
                            r_edge  <= r_edge + CNT_W'(1);
                            r_raddr <= (r_edge + CNT_W'(2) >= r_n) ? '0
                                       : ADDR_W'(r_edge + CNT_W'(2));
                            r_state <= ST_FETCH0;
                        end
                    end
                end
                ST_DONE: begin
                    r_out_valid <= 1'b1;
                    r_state     <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/prc_checker.sv
`include "assert_macros.svh"

module prc_checker
    import prc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic i_req_type,
    input logic o_valid,
    input logic i_stall,
    input logic o_in_region
);

    // No input transfer while a result waits
    `PRC_ASSERT(a_no_take_busy, i_clk, i_rst_n, o_valid |-> o_stall, "input taken while result held")
    // A stalled result holds
    `PRC_ASSERT(a_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_in_region)), "stalled result changed")
    // A load gives no result
    `PRC_ASSERT(a_load_quiet, i_clk, i_rst_n, (i_valid && !o_stall && i_req_type == REQ_LOAD) |=> !o_valid ##1 !o_valid, "load produced a result")
    // Reset leaves no result pending
    `PRC_ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind point_region_classifier_unit prc_checker u_prc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_req_type  (i_req_type),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_in_region (o_in_region)
);
